/* sv/fisr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisr_pkg
// types, constants and binary32 arithmetic steps shared by the rsqrt core
// ----------------------------------------------------------------------------
package fisr_pkg;

    localparam logic [31:0] MAGIC_GUESS = 32'h5f3759df;
    localparam logic [31:0] CANON_QNAN  = 32'h7fc00000;
    localparam logic [31:0] FP_HALF     = 32'h3f000000;
    localparam logic [31:0] FP_ONE_HALF = 32'h3fc00000;

    // front and back stage for each of the five operations
    localparam int NSTG = 10;

    // product ahead of normalize and round
    typedef struct packed {
        logic        sign;
        logic        is_nan;
        logic        is_inf;
        logic [9:0]  esum;
        logic [47:0] prod;
    } mul_mid_t;

    // aligned sum ahead of normalize and round
    typedef struct packed {
        logic        sign;
        logic        zsign;
        logic        is_nan;
        logic        is_inf;
        logic [7:0]  exp;
        logic [27:0] sum;
    } add_mid_t;

    function automatic logic is_nan32(input logic [31:0] a);
        return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf32(input logic [31:0] a);
        return (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero32(input logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    function automatic mul_mid_t mul_front(input logic [31:0] a, input logic [31:0] b);
        mul_mid_t   r;
        logic [7:0] ea;
        logic [7:0] eb;
        logic [23:0] sa;
        logic [23:0] sb;
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        sa = {(a[30:23] != 8'd0), a[22:0]};
        sb = {(b[30:23] != 8'd0), b[22:0]};
        r.sign   = a[31] ^ b[31];
        r.is_nan = is_nan32(a) || is_nan32(b) || (is_inf32(a) && is_zero32(b)) ||
                   (is_zero32(a) && is_inf32(b));
        r.is_inf = is_inf32(a) || is_inf32(b);
        r.esum   = {2'b00, ea} + {2'b00, eb};
        r.prod   = sa * sb;
        return r;
    endfunction

    function automatic logic [31:0] mul_back(input mul_mid_t m);
        logic [5:0]         lead;
        logic signed [11:0] kn;
        logic signed [11:0] ks;
        logic signed [11:0] k;
        logic signed [11:0] eb;
        logic [5:0]         kk;
        logic [47:0]        q;
        logic [47:0]        tmp;
        logic [47:0]        mask;
        logic               g;
        logic               s;
        logic               inc;
        logic [24:0]        m25;
        logic [23:0]        mant;
        logic [7:0]         ef;
        logic [31:0]        r;
        lead = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (m.prod[i])
                lead = i[5:0];
        end
        kn = $signed({6'd0, lead}) - 12'sd23;
        ks = 12'sd151 - $signed({2'b00, m.esum});
        k  = (kn > ks) ? kn : ks;
        g  = 1'b0;
        s  = 1'b0;
        kk = 6'd0;
        if (k < 12'sd0)
        begin
            q = m.prod << (-k);
        end
        else
        begin
            kk   = (k > 12'sd49) ? 6'd49 : k[5:0];
            q    = m.prod >> kk;
            tmp  = (kk != 6'd0) ? (m.prod >> (kk - 6'd1)) : 48'd0;
            g    = (kk != 6'd0) && (kk <= 6'd48) && tmp[0];
            if (kk <= 6'd1)
                mask = 48'd0;
            else if (kk >= 6'd49)
                mask = {48{1'b1}};
            else
                mask = (48'd1 << (kk - 6'd1)) - 48'd1;
            s = (m.prod & mask) != 48'd0;
        end
        mant = q[23:0];
        inc  = g & (s | mant[0]);
        m25  = {1'b0, mant} + {24'd0, inc};
        eb   = k + $signed({2'b00, m.esum}) - 12'sd150;
        if (m25[24])
        begin
            mant = m25[24:1];
            eb   = eb + 12'sd1;
        end
        else
        begin
            mant = m25[23:0];
        end
        ef = mant[23] ? eb[7:0] : 8'd0;
        if (m.is_nan)
            r = CANON_QNAN;
        else if (m.is_inf || (eb >= 12'sd255 && m.prod != 48'd0))
            r = {m.sign, 8'hff, 23'd0};
        else if (m.prod == 48'd0)
            r = {m.sign, 31'd0};
        else
            r = {m.sign, ef, mant[22:0]};
        return r;
    endfunction

    function automatic add_mid_t add_front(input logic [31:0] a, input logic [31:0] b);
        add_mid_t    r;
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  e_big;
        logic [7:0]  e_sml;
        logic [7:0]  d;
        logic [26:0] bext;
        logic [26:0] bsh;
        logic        st;
        logic [27:0] aext;
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        d     = e_big - e_sml;
        aext  = {1'b0, (big[30:23] != 8'd0), big[22:0], 3'b000};
        bext  = {(sml[30:23] != 8'd0), sml[22:0], 3'b000};
        if (d >= 8'd27)
        begin
            bsh = 27'd0;
            st  = bext != 27'd0;
        end
        else
        begin
            bsh = bext >> d;
            st  = (bext & ((27'd1 << d) - 27'd1)) != 27'd0;
        end
        bsh[0]   = bsh[0] | st;
        r.sign   = big[31];
        r.zsign  = a[31] & b[31];
        r.is_nan = is_nan32(a) || is_nan32(b) ||
                   (is_inf32(a) && is_inf32(b) && (a[31] != b[31]));
        r.is_inf = is_inf32(a) || is_inf32(b);
        r.exp    = e_big;
        r.sum    = (a[31] == b[31]) ? (aext + {1'b0, bsh}) : (aext - {1'b0, bsh});
        return r;
    endfunction

    function automatic logic [31:0] add_back(input add_mid_t m);
        logic [4:0]  lz;
        logic        found;
        logic [9:0]  e;
        logic [9:0]  sh;
        logic [26:0] r27;
        logic        g;
        logic        s;
        logic        inc;
        logic [24:0] m25;
        logic [23:0] mant;
        logic [7:0]  ef;
        logic [31:0] r;
        e     = {2'b00, m.exp};
        lz    = 5'd0;
        found = 1'b0;
        for (int i = 26; i >= 0; i--)
        begin
            if (!found && !m.sum[i])
                lz = lz + 5'd1;
            else
                found = 1'b1;
        end
        if (m.sum[27])
        begin
            r27 = {m.sum[27:2], m.sum[1] | m.sum[0]};
            e   = e + 10'd1;
        end
        else
        begin
            sh  = ({5'd0, lz} < (e - 10'd1)) ? {5'd0, lz} : (e - 10'd1);
            r27 = m.sum[26:0] << sh;
            e   = e - sh;
        end
        mant = r27[26:3];
        g    = r27[2];
        s    = r27[1] | r27[0];
        inc  = g & (s | mant[0]);
        m25  = {1'b0, mant} + {24'd0, inc};
        if (m25[24])
        begin
            mant = m25[24:1];
            e    = e + 10'd1;
        end
        else
        begin
            mant = m25[23:0];
        end
        ef = mant[23] ? e[7:0] : 8'd0;
        if (m.is_nan)
            r = CANON_QNAN;
        else if (m.is_inf)
            r = {m.sign, 8'hff, 23'd0};
        else if (m.sum == 28'd0)
            r = {m.zsign, 31'd0};
        else if (e >= 10'd255)
            r = {m.sign, 8'hff, 23'd0};
        else
            r = {m.sign, ef, mant[22:0]};
        return r;
    endfunction

endpackage

/* sv/fisr_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisr_in_if
// request channel carrying one binary32 operand pattern
// ----------------------------------------------------------------------------
interface fisr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_bits;

    modport source (output valid, output x_bits, input ready);
    modport sink   (input valid, input x_bits, output ready);
endinterface

/* sv/fisr_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisr_out_if
// result channel carrying one binary32 reciprocal square root pattern
// ----------------------------------------------------------------------------
interface fisr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] y_bits;

    modport source (output valid, output y_bits, input ready);
    modport sink   (input valid, input y_bits, output ready);
endinterface

/* sv/fast_inverse_square_root_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_inverse_square_root_core
// magic-constant guess plus one binary32 newton step, ten-stage pipeline
// ----------------------------------------------------------------------------
// Accepts one request per cycle while the pipeline is not stalled and returns
// one result per request, in order. The stages follow the newton step: four
// binary32 multiplies and one add, each cut into a front stage (multiply or
// align) and a back stage (normalize and round to nearest even). Every stage
// has its own valid bit and stalls only when it is full and its successor
// cannot take its contents, so bubbles collapse under back pressure. NaN
// results come out as 0x7FC00000; subnormals are handled in full.
module fast_inverse_square_root_core
(
    input  logic       clk,
    input  logic       rst_n,
    fisr_in_if.sink    arg,
    fisr_out_if.source res
);
    import fisr_pkg::*;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] rdy;

    logic [31:0] x1_reg;
    logic [31:0] y1_reg, y2_reg, y3_reg, y4_reg, y5_reg, y6_reg, y7_reg, y8_reg;
    mul_mid_t    h_mid_reg, p_mid_reg, t_mid_reg, r_mid_reg;
    add_mid_t    u_mid_reg;
    logic [31:0] h_reg, p_reg, t_reg, u_reg, r_reg;
    logic [31:0] guess;

    assign guess = MAGIC_GUESS - {arg.x_bits[31], arg.x_bits[31:1]};

    always_comb
    begin
        rdy[NSTG-1] = !v_reg[NSTG-1] || res.ready;
        for (int i = NSTG - 2; i >= 0; i--)
            rdy[i] = !v_reg[i] || rdy[i+1];
    end

    assign arg.ready  = rdy[0];
    assign res.valid  = v_reg[NSTG-1];
    assign res.y_bits = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= arg.valid;
            for (int i = 1; i < NSTG; i++)
            begin
                if (rdy[i])
                    v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            h_mid_reg <= mul_front(arg.x_bits, FP_HALF);
            x1_reg    <= arg.x_bits;
            y1_reg    <= guess;
        end
        if (rdy[1])
        begin
            h_reg  <= mul_back(h_mid_reg);
            y2_reg <= y1_reg;
        end
        if (rdy[2])
        begin
            p_mid_reg <= mul_front(h_reg, y2_reg);
            y3_reg    <= y2_reg;
        end
        if (rdy[3])
        begin
            p_reg  <= mul_back(p_mid_reg);
            y4_reg <= y3_reg;
        end
        if (rdy[4])
        begin
            t_mid_reg <= mul_front(p_reg, y4_reg);
            y5_reg    <= y4_reg;
        end
        if (rdy[5])
        begin
            t_reg  <= mul_back(t_mid_reg);
            y6_reg <= y5_reg;
        end
        // 1.5 - t as 1.5 + (-t)
        if (rdy[6])
        begin
            u_mid_reg <= add_front(FP_ONE_HALF, {~t_reg[31], t_reg[30:0]});
            y7_reg    <= y6_reg;
        end
        if (rdy[7])
        begin
            u_reg  <= add_back(u_mid_reg);
            y8_reg <= y7_reg;
        end
        if (rdy[8])
            r_mid_reg <= mul_front(y8_reg, u_reg);
        if (rdy[9])
            r_reg <= mul_back(r_mid_reg);
    end

    // input pattern is only kept for a check on the halving stage
    logic x1_nan;
    assign x1_nan = is_nan32(x1_reg);

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (arg.valid && arg.ready) |=> v_reg[0])
        else $error("accepted request did not enter the first stage");

    a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[4] && !rdy[5]) |=> v_reg[4])
        else $error("stalled stage lost its item");

    a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && is_nan32(res.y_bits)) |-> (res.y_bits == CANON_QNAN))
        else $error("result nan is not canonical");

    a_half_nan: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[0] && rdy[1] && x1_nan) |=> (h_reg == CANON_QNAN))
        else $error("nan operand did not propagate through halving");

endmodule
